### rtl/core/sbox_pkg.sv
// Shared types and constants for the segment/box overlap classifier.
package sbox_pkg;

   localparam int FIELD_BITS  = 32;
   localparam int LEVEL_BITS  = 6;
   localparam int COUNT_BITS  = 4;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [COUNT_BITS-1:0] REQUIRED_COUNT = 4'd4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SEG_START_X = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEG_START_Y = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEG_END_X   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEG_END_Y   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COORD_COUNT = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PARAM_COUNT = 3'd5;

   localparam logic [1:0] CONT_NONE  = 2'd0;
   localparam logic [1:0] CONT_PART  = 2'd1;
   localparam logic [1:0] CONT_FULL  = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Load enables of the product and difference stages inside a crossing unit.
   typedef struct packed {
      logic prod_ld;
      logic diff_ld;
   } sbox_adv_type;

endpackage

### rtl/core/sbox_req_if.sv
// Request and response channel interfaces of the overlap classifier.
interface sbox_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] box_min_x;
   logic [31:0] box_max_x;
   logic [31:0] box_min_y;
   logic [31:0] box_max_y;
   logic [5:0]  tree_level;
   modport source (output valid, box_min_x, box_max_x, box_min_y, box_max_y, tree_level,
                   input ready);
   modport sink   (input valid, box_min_x, box_max_x, box_min_y, box_max_y, tree_level,
                   output ready);
endinterface

interface sbox_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [1:0] containment;
   logic       touches;
   logic [5:0] score;
   modport source (output valid, status, containment, touches, score, input ready);
   modport sink   (input valid, status, containment, touches, score, output ready);
endinterface

### rtl/core/sbox_cross.sv
// Crossing test of the query segment against one box diagonal, two register stages.
module sbox_cross
   import sbox_pkg::*;
#(
   parameter int DW = 33
) (
   input  logic                 clock,
   input  sbox_adv_type         adv,
   input  logic signed [DW-1:0] bx,
   input  logic signed [DW-1:0] by,
   input  logic signed [DW-1:0] dx,
   input  logic signed [DW-1:0] dy,
   input  logic signed [DW-1:0] cx,
   input  logic signed [DW-1:0] cy,
   output logic                 crosses
);
   localparam int PW = 2 * DW;
   localparam int CW = PW + 1;

   logic signed [PW-1:0] p_bdy_ff, p_bydx_ff, p_cxdy_ff, p_cydx_ff, p_cxby_ff, p_cybx_ff;
   logic signed [CW-1:0] den_ff, tnum_ff, unum_ff;
   logic signed [CW-1:0] den_in, tnum_in, unum_in;
   logic                 den_neg, t_ok, u_ok;

   always_ff @(posedge clock) begin
      if (adv.prod_ld) begin
         p_bdy_ff  <= PW'(bx * dy);
         p_bydx_ff <= PW'(by * dx);
         p_cxdy_ff <= PW'(cx * dy);
         p_cydx_ff <= PW'(cy * dx);
         p_cxby_ff <= PW'(cx * by);
         p_cybx_ff <= PW'(cy * bx);
      end
   end

   always_comb begin
      den_in  = CW'(p_bdy_ff)  - CW'(p_bydx_ff);
      tnum_in = CW'(p_cxdy_ff) - CW'(p_cydx_ff);
      unum_in = CW'(p_cxby_ff) - CW'(p_cybx_ff);
   end

   always_ff @(posedge clock) begin
      if (adv.diff_ld) begin
         den_ff  <= den_in;
         tnum_ff <= tnum_in;
         unum_ff <= unum_in;
      end
   end

   // Both parameters must lie in [0,1]: compare against the denominator by sign.
   always_comb begin
      den_neg = den_ff[CW-1];
      if (den_neg) begin
         t_ok = (den_ff <= tnum_ff) && (tnum_ff <= 0);
         u_ok = (den_ff <= unum_ff) && (unum_ff <= 0);
      end else begin
         t_ok = (tnum_ff >= 0) && (tnum_ff <= den_ff);
         u_ok = (unum_ff >= 0) && (unum_ff <= den_ff);
      end
      crosses = (den_ff != '0) && t_ok && u_ok;
   end

endmodule

### rtl/core/segment_box_overlap_classifier_unit.sv
// Top level of the segment/box overlap classifier pipeline.
//
//   channel   direction  payload                                       transfer when
//   req_ch    in         box_min_x/max_x/min_y/max_y, tree_level       valid && ready
//   rsp_ch    out        status, containment, touches, score           valid && ready
//   csr_*     in         csr_index, csr_wdata                          csr_we
//
// One box enters per cycle unless a stall on rsp_ch holds the pipe; each result passes
// the decode, multiply, subtract and classify registers in turn before rsp_ch offers it.
// Reset is synchronous, active high; it clears the stage valid bits and loads the
// configuration defaults (zero segment, both counts four).
// Each stage holds while the stage after it is full and stalled, so a stall on
// rsp_ch backs up stage by stage and nothing is dropped or repeated.
module segment_box_overlap_classifier_unit
   import sbox_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   sbox_req_if.sink                 req_ch,
   sbox_rsp_if.source               rsp_ch,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [FIELD_BITS-1:0]    csr_wdata
);
   // Coordinates wider than the field fall back to the field width.
   localparam int W  = (COORD_BITS > FIELD_BITS) ? FIELD_BITS : COORD_BITS;
   localparam int DW = W + 1;

   // ---------------- configuration registers ----------------
   logic [FIELD_BITS-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [COUNT_BITS-1:0] coord_cnt_ff, param_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff        <= '0;
         sy_ff        <= '0;
         ex_ff        <= '0;
         ey_ff        <= '0;
         coord_cnt_ff <= REQUIRED_COUNT;
         param_cnt_ff <= REQUIRED_COUNT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEG_START_X: sx_ff        <= csr_wdata;
            CSR_SEG_START_Y: sy_ff        <= csr_wdata;
            CSR_SEG_END_X:   ex_ff        <= csr_wdata;
            CSR_SEG_END_Y:   ey_ff        <= csr_wdata;
            CSR_COORD_COUNT: coord_cnt_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_PARAM_COUNT: param_cnt_ff <= csr_wdata[COUNT_BITS-1:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // ---------------- stage handshake ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic ld1, ld2, ld3, ld4;

   // A stage loads when it is empty or its content moves on this cycle.
   assign ld4 = !v4_ff || rsp_ch.ready;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign req_ch.ready = ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= req_ch.valid;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: decode, inside tests, differences ----------------
   logic signed [W-1:0]  x0, x1, y0, y1, ax, ay, bx, by;
   logic                 err_in, ina_in, inb_in;
   logic signed [DW-1:0] sbx_in, sby_in, dx_in, dy1_in, dy2_in, cx_in, cy1_in, cy2_in;

   always_comb begin
      x0 = req_ch.box_min_x[W-1:0];
      x1 = req_ch.box_max_x[W-1:0];
      y0 = req_ch.box_min_y[W-1:0];
      y1 = req_ch.box_max_y[W-1:0];
      ax = sx_ff[W-1:0];
      ay = sy_ff[W-1:0];
      bx = ex_ff[W-1:0];
      by = ey_ff[W-1:0];
      err_in = (coord_cnt_ff != REQUIRED_COUNT) || (param_cnt_ff != REQUIRED_COUNT);
      // Edges count as inside; an inverted box holds no point.
      ina_in = (ax >= x0) && (ax <= x1) && (ay >= y0) && (ay <= y1);
      inb_in = (bx >= x0) && (bx <= x1) && (by >= y0) && (by <= y1);
      sbx_in = DW'(bx) - DW'(ax);
      sby_in = DW'(by) - DW'(ay);
      dx_in  = DW'(x1) - DW'(x0);
      dy1_in = DW'(y1) - DW'(y0);   // diagonal (x0,y0)-(x1,y1)
      dy2_in = DW'(y0) - DW'(y1);   // diagonal (x0,y1)-(x1,y0)
      cx_in  = DW'(x0) - DW'(ax);
      cy1_in = DW'(y0) - DW'(ay);
      cy2_in = DW'(y1) - DW'(ay);
   end

   logic                  err1_ff, ina1_ff, inb1_ff;
   logic [LEVEL_BITS-1:0] lvl1_ff;
   logic signed [DW-1:0]  sbx_ff, sby_ff, dx_ff, dy1_ff, dy2_ff, cx_ff, cy1_ff, cy2_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         err1_ff <= err_in;
         ina1_ff <= ina_in;
         inb1_ff <= inb_in;
         lvl1_ff <= req_ch.tree_level;
         sbx_ff  <= sbx_in;
         sby_ff  <= sby_in;
         dx_ff   <= dx_in;
         dy1_ff  <= dy1_in;
         dy2_ff  <= dy2_in;
         cx_ff   <= cx_in;
         cy1_ff  <= cy1_in;
         cy2_ff  <= cy2_in;
      end
   end

   // ---------------- stages 2 and 3: cross products per diagonal ----------------
   sbox_adv_type adv;
   logic         cross_main, cross_anti;

   assign adv.prod_ld = ld2;
   assign adv.diff_ld = ld3;

   sbox_cross #(.DW(DW)) u_cross_main (
      .clock   (clock),
      .adv     (adv),
      .bx      (sbx_ff),
      .by      (sby_ff),
      .dx      (dx_ff),
      .dy      (dy1_ff),
      .cx      (cx_ff),
      .cy      (cy1_ff),
      .crosses (cross_main)
   );

   sbox_cross #(.DW(DW)) u_cross_anti (
      .clock   (clock),
      .adv     (adv),
      .bx      (sbx_ff),
      .by      (sby_ff),
      .dx      (dx_ff),
      .dy      (dy2_ff),
      .cx      (cx_ff),
      .cy      (cy2_ff),
      .crosses (cross_anti)
   );

   // Side band travels alongside the crossing units.
   logic                  err2_ff, ina2_ff, inb2_ff, err3_ff, ina3_ff, inb3_ff;
   logic [LEVEL_BITS-1:0] lvl2_ff, lvl3_ff;

   always_ff @(posedge clock) begin
      if (ld2) begin
         err2_ff <= err1_ff;
         ina2_ff <= ina1_ff;
         inb2_ff <= inb1_ff;
         lvl2_ff <= lvl1_ff;
      end
      if (ld3) begin
         err3_ff <= err2_ff;
         ina3_ff <= ina2_ff;
         inb3_ff <= inb2_ff;
         lvl3_ff <= lvl2_ff;
      end
   end

   // ---------------- stage 4: classify into the output register ----------------
   logic                  status_in, touches_in;
   logic [1:0]            cont_in;
   logic [LEVEL_BITS-1:0] score_in;

   always_comb begin
      priority if (ina3_ff && inb3_ff) begin
         cont_in = CONT_FULL;
      end else if (ina3_ff || inb3_ff || cross_main || cross_anti) begin
         cont_in = CONT_PART;
      end else begin
         cont_in = CONT_NONE;
      end
      if (err3_ff) begin
         status_in  = STATUS_ERR;
         cont_in    = CONT_NONE;
         touches_in = 1'b0;
         score_in   = '0;
      end else begin
         status_in  = STATUS_OK;
         touches_in = (cont_in != CONT_NONE);
         score_in   = lvl3_ff;
      end
   end

   logic                  status_ff, touches_ff;
   logic [1:0]            cont_ff;
   logic [LEVEL_BITS-1:0] score_ff;

   always_ff @(posedge clock) begin
      if (ld4) begin
         status_ff  <= status_in;
         cont_ff    <= cont_in;
         touches_ff <= touches_in;
         score_ff   <= score_in;
      end
   end

   assign rsp_ch.valid       = v4_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.containment = cont_ff;
   assign rsp_ch.touches     = touches_ff;
   assign rsp_ch.score       = score_ff;

endmodule

### bench/sbox_tb_if.sv
`timescale 1ns / 100ps
// Item types shared by the overlap classifier bench.
package sbox_tb_types;
   typedef struct packed {
      logic [31:0] min_x;
      logic [31:0] max_x;
      logic [31:0] min_y;
      logic [31:0] max_y;
      logic [5:0]  level;
   } box_item_type;

   typedef struct packed {
      logic       status;
      logic [1:0] containment;
      logic       touches;
      logic [5:0] score;
   } overlap_type;
endpackage

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the segment/box overlap classifier.
module tb;
   import sbox_pkg::*;
   import sbox_tb_types::*;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [31:0] csr_wdata;

   sbox_req_if req_ch();
   sbox_rsp_if rsp_ch();

   segment_box_overlap_classifier_unit uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the block's configuration.
   logic signed [31:0] q_sx, q_sy, q_ex, q_ey;
   logic [3:0] q_coord_cnt, q_param_cnt;

   overlap_type expected_overlaps[$];
   int fail_count;
   bit rsp_stall_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // Exact cross product; 33-bit differences fit easily in 70 bits.
   function automatic logic signed [71:0] cross2(input logic signed [35:0] ax,
         input logic signed [35:0] ay, input logic signed [35:0] bx,
         input logic signed [35:0] by);
      logic signed [71:0] p, q;
      p = ax * by;
      q = ay * bx;
      return p - q;
   endfunction

   function automatic bit ratio_in_unit(input logic signed [71:0] num,
                                        input logic signed [71:0] den);
      if (den > 0) return num >= 0 && num <= den;
      return num <= 0 && num >= den;
   endfunction

   // Segment P1-P2 against Q1-Q2; parallel or degenerate pairs never cross.
   function automatic bit crosses(input logic signed [35:0] p1x, p1y, p2x, p2y,
                                  input logic signed [35:0] q1x, q1y, q2x, q2y);
      logic signed [35:0] bx, by, dx, dy, cx, cy;
      logic signed [71:0] den;
      bx = p2x - p1x; by = p2y - p1y;
      dx = q2x - q1x; dy = q2y - q1y;
      cx = q1x - p1x; cy = q1y - p1y;
      den = cross2(bx, by, dx, dy);
      if (den == 0) return 1'b0;
      if (!ratio_in_unit(cross2(cx, cy, dx, dy), den)) return 1'b0;
      return ratio_in_unit(cross2(cx, cy, bx, by), den);
   endfunction

   function automatic overlap_type classify_box(input box_item_type b);
      overlap_type r;
      logic signed [35:0] x0, x1, y0, y1, ax, ay, bx, by;
      bit ina, inb;
      r = '0;
      if (q_coord_cnt != REQUIRED_COUNT || q_param_cnt != REQUIRED_COUNT) begin
         r.status = STATUS_ERR;
         return r;
      end
      x0 = $signed(b.min_x); x1 = $signed(b.max_x);
      y0 = $signed(b.min_y); y1 = $signed(b.max_y);
      ax = q_sx; ay = q_sy; bx = q_ex; by = q_ey;
      ina = ax >= x0 && ax <= x1 && ay >= y0 && ay <= y1;
      inb = bx >= x0 && bx <= x1 && by >= y0 && by <= y1;
      if (ina && inb) r.containment = CONT_FULL;
      else if (ina || inb) r.containment = CONT_PART;
      else if (crosses(ax, ay, bx, by, x0, y0, x1, y1) ||
               crosses(ax, ay, bx, by, x0, y1, x1, y0)) r.containment = CONT_PART;
      else r.containment = CONT_NONE;
      r.status = STATUS_OK;
      r.touches = r.containment != CONT_NONE;
      r.score = b.level;
      return r;
   endfunction

   // Response side: random stall, then compare every transfer.
   initial begin
      int gap;
      overlap_type want;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_overlaps.size() == 0) begin
               $display("unexpected result at %0t", $realtime);
               fail_count++;
            end else begin
               want = expected_overlaps.pop_front();
               if (rsp_ch.status !== want.status) report("status", rsp_ch.status, want.status);
               if (rsp_ch.containment !== want.containment)
                  report("containment", rsp_ch.containment, want.containment);
               if (rsp_ch.touches !== want.touches) report("touches", rsp_ch.touches, want.touches);
               if (rsp_ch.score !== want.score) report("score", rsp_ch.score, want.score);
            end
         end
         if (!rsp_ch.ready || rsp_ch.valid) begin
            gap = rsp_stall_on ? $urandom_range(0, 11) : 0;
            if (gap > 0 && rsp_ch.ready) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap - 1) @(posedge clock);
               // the next loop pass raises ready
            end else rsp_ch.ready <= 1'b1;
         end
      end
   end

   bit send_gaps;

   // Send one box; hold valid until the transfer and leave it high for a follow-on.
   task automatic send_box(input box_item_type b);
      int gap;
      gap = send_gaps ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.box_min_x <= b.min_x; req_ch.box_max_x <= b.max_x;
      req_ch.box_min_y <= b.min_y; req_ch.box_max_y <= b.max_y;
      req_ch.tree_level <= b.level;
      do @(posedge clock); while (!req_ch.ready);
      expected_overlaps.push_back(classify_box(b));
   endtask

   // Drop valid and wait until every expected result has come.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_overlaps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [31:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SEG_START_X: q_sx = val;
         CSR_SEG_START_Y: q_sy = val;
         CSR_SEG_END_X:   q_ex = val;
         CSR_SEG_END_Y:   q_ey = val;
         CSR_COORD_COUNT: q_coord_cnt = val[3:0];
         CSR_PARAM_COUNT: q_param_cnt = val[3:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_segment(input logic [31:0] sx, sy, ex, ey);
      drain();
      write_reg(CSR_SEG_START_X, sx); write_reg(CSR_SEG_START_Y, sy);
      write_reg(CSR_SEG_END_X, ex);   write_reg(CSR_SEG_END_Y, ey);
   endtask

   function automatic box_item_type mk_box(input logic [31:0] x0, x1, y0, y1,
                                           input logic [5:0] l);
      box_item_type b;
      b.min_x = x0; b.max_x = x1; b.min_y = y0; b.max_y = y1; b.level = l;
      return b;
   endfunction

   // Coordinate from a small window most of the time, otherwise a full-range value or an extreme.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom_range(0, 40) - 20;
      endcase
   endfunction

   function automatic box_item_type rand_box();
      logic [31:0] a, b, c, d;
      a = rand_coord(); b = rand_coord(); c = rand_coord(); d = rand_coord();
      // mostly well-ordered boxes, a few inverted
      if ($urandom_range(0, 7) != 0) begin
         if ($signed(a) > $signed(b)) begin logic [31:0] t; t = a; a = b; b = t; end
         if ($signed(c) > $signed(d)) begin logic [31:0] t; t = c; c = d; d = t; end
      end
      return mk_box(a, b, c, d, $urandom_range(0, 63));
   endfunction

   task automatic test_directed();
      set_segment(-5, 0, 5, 0);
      send_box(mk_box(-10, 10, -10, 10, 63));   // fully within
      send_box(mk_box(-5, 5, 0, 0, 0));         // edges inclusive
      send_box(mk_box(0, 10, -1, 1, 1));        // one endpoint inside
      send_box(mk_box(-1, 1, -1, 1, 2));        // crosses diagonals
      send_box(mk_box(-1, 1, 5, 9, 3));         // miss
      send_box(mk_box(1, -1, 1, -1, 4));        // inverted box
      send_box(mk_box(-9, 9, 0, 0, 5));         // collinear diagonal
      send_box(mk_box(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 6));
      send_box(mk_box(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 7));
      set_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
      send_box(mk_box(-3, 3, -3, 3, 8));
      send_box(mk_box(32'h80000000, 0, 0, 32'h7fffffff, 9));
      send_box(mk_box(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 10));
      set_segment(7, 7, 7, 7);                  // degenerate segment
      send_box(mk_box(0, 5, 0, 5, 11));
      send_box(mk_box(0, 9, 0, 9, 12));
   endtask

   task automatic test_counts();
      logic [3:0] bad;
      drain();
      write_reg(CSR_COORD_COUNT, 0);
      send_box(mk_box(0, 9, 0, 9, 33));
      drain();
      write_reg(CSR_COORD_COUNT, 4); write_reg(CSR_PARAM_COUNT, 15);
      send_box(mk_box(0, 9, 0, 9, 34));
      for (int i = 0; i < 20; i++) begin
         drain();
         bad = $urandom_range(0, 15);
         write_reg($urandom_range(0, 1) ? CSR_COORD_COUNT : CSR_PARAM_COUNT, bad);
         send_box(rand_box());
      end
      drain();
      write_reg(CSR_COORD_COUNT, 32'hfffffff4); write_reg(CSR_PARAM_COUNT, 4);
      write_reg(3'd6, 32'hffffffff); write_reg(3'd7, 0);   // unknown indexes ignored
      send_box(mk_box(0, 9, 0, 9, 35));
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 15; phase++) begin
         set_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
         send_gaps = phase % 3 != 0;
         rsp_stall_on = phase % 4 != 1;
         for (int i = 0; i < 100; i++) begin
            send_box(rand_box());
            if (phase == 5 && i == 50) drain();
         end
      end
   endtask

   initial begin
      fail_count = 0;
      reset = 1'b1; csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      req_ch.valid = 1'b0; req_ch.box_min_x = '0; req_ch.box_max_x = '0;
      req_ch.box_min_y = '0; req_ch.box_max_y = '0; req_ch.tree_level = '0;
      q_sx = 0; q_sy = 0; q_ex = 0; q_ey = 0;
      q_coord_cnt = REQUIRED_COUNT; q_param_cnt = REQUIRED_COUNT;
      send_gaps = 1; rsp_stall_on = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_box(mk_box(-1, 1, -1, 1, 17));       // reset segment at origin
      test_directed();
      test_counts();
      test_random();
      drain();
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
